>>> design/csvfs_pkg.sv
// Shared types and the per-byte step function of the CSV field splitter.
// Used by csvfs_parser and csv_field_splitter_top; no dependencies.
package csvfs_pkg;

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_FEND = 2'd1,
    KIND_REND = 2'd2
  } csvfs_kind_e;

  typedef struct packed {
    logic quoting;
    logic field_empty;
    logic held_cr;
    logic held_quote;
    logic record_open;
  } csvfs_state_t;

  localparam csvfs_state_t STATE_RESET = '{
    quoting: 1'b0, field_empty: 1'b1, held_cr: 1'b0, held_quote: 1'b0, record_open: 1'b0
  };

  typedef struct packed {
    csvfs_kind_e kind;
    logic [7:0]  data;
  } csvfs_res_t;

  // Working context of one step: state plus up to two results.
  typedef struct packed {
    csvfs_state_t st;
    logic [1:0]   cnt;
    csvfs_res_t   r1;
    csvfs_res_t   r0;
  } csvfs_ctx_t;

  function automatic csvfs_ctx_t emit(csvfs_ctx_t c, csvfs_kind_e k, logic [7:0] b);
    csvfs_res_t r;
    r.kind = k;
    r.data = (k == KIND_BYTE) ? b : 8'h00;
    if (c.cnt == 2'd0) begin
      c.r0 = r;
    end else if (c.cnt == 2'd1) begin
      c.r1 = r;
    end
    if (c.cnt != 2'd2) begin
      c.cnt = c.cnt + 2'd1;
    end
    return c;
  endfunction

  function automatic csvfs_ctx_t end_record(csvfs_ctx_t c);
    csvfs_ctx_t o;
    o = emit(c, KIND_REND, 8'h00);
    o.st.quoting     = 1'b0;
    o.st.field_empty = 1'b1;
    o.st.held_quote  = 1'b0;
    o.st.record_open = 1'b0;
    return o;
  endfunction

  // Byte whose CR and quote handling is already settled.
  function automatic csvfs_ctx_t plain_byte(csvfs_ctx_t c, logic [7:0] ch);
    csvfs_ctx_t o;
    o = c;
    o.st.record_open = 1'b1;
    if (!o.st.quoting && ch == CH_LF) begin
      return end_record(o);
    end
    if (!o.st.quoting && (ch == CH_SEMI || ch == CH_COMMA)) begin
      o = emit(o, KIND_FEND, 8'h00);
      o.st.field_empty = 1'b1;
      return o;
    end
    o = emit(o, KIND_BYTE, ch);
    o.st.field_empty = 1'b0;
    return o;
  endfunction

  function automatic csvfs_ctx_t normal_byte(csvfs_ctx_t c, logic [7:0] ch);
    csvfs_ctx_t o;
    o = c;
    o.st.record_open = 1'b1;
    if (ch == CH_CR) begin
      o.st.held_cr = 1'b1;
      return o;
    end
    if (ch == CH_QUOTE) begin
      if (o.st.quoting) begin
        o.st.held_quote = 1'b1;
      end else if (o.st.field_empty) begin
        o.st.quoting = 1'b1;
      end else begin
        o = emit(o, KIND_BYTE, ch);
        o.st.field_empty = 1'b0;
      end
      return o;
    end
    return plain_byte(o, ch);
  endfunction

  function automatic csvfs_ctx_t step(csvfs_state_t st, logic [7:0] b, logic eoi);
    csvfs_ctx_t c;
    c     = '0;
    c.st  = st;
    if (eoi) begin
      if (c.st.held_cr) begin
        c.st.held_cr = 1'b0;
        c = plain_byte(c, CH_LF);
      end
      if (c.st.held_quote) begin
        c.st.held_quote = 1'b0;
        c.st.quoting    = 1'b0;
      end
      if (c.st.record_open) begin
        c = end_record(c);
      end
      c.st = STATE_RESET;
    end else if (c.st.held_cr) begin
      c.st.held_cr = 1'b0;
      c = plain_byte(c, CH_LF);
      if (b != CH_LF) begin
        c = normal_byte(c, b);
      end
    end else if (c.st.held_quote) begin
      c.st.held_quote = 1'b0;
      if (b == CH_QUOTE) begin
        c.st.record_open = 1'b1;
        c = emit(c, KIND_BYTE, CH_QUOTE);
        c.st.field_empty = 1'b0;
      end else begin
        c.st.quoting = 1'b0;
        c = normal_byte(c, b);
      end
    end else begin
      c = normal_byte(c, b);
    end
    return c;
  endfunction

endpackage

>>> design/csvfs_parser.sv
// Parser state registers and the per-beat step logic of the CSV splitter.
// Depends on csvfs_pkg.
module csvfs_parser import csvfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  input  logic       eoi_i,
  output csvfs_ctx_t ctx_o
);

  csvfs_state_t st_q, st_d;
  csvfs_ctx_t   ctx;

  always_comb begin
    ctx  = step(st_q, byte_i, eoi_i);
    st_d = accept_i ? ctx.st : st_q;
  end

  assign ctx_o = ctx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= STATE_RESET;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

>>> design/csv_field_splitter_top.sv
// CSV field splitter: input beats of one byte or an end mark, output beats
// of field bytes, field ends and record ends. Depends on csvfs_pkg, csvfs_parser.
// Each result of a beat is registered in the result queue before it appears at the output.
// Throughput: one input beat per cycle while two queue slots are free; a beat that
// yields two results puts both into the 4-entry result queue, which absorbs the surplus.
// Reset (async, active low) empties the queue and returns the parser to idle.
module csv_field_splitter_top import csvfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // end_of_input
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser,   // [1:0] kind
  output logic       m_axis_tlast    // last result of its input beat
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  typedef struct packed {
    csvfs_kind_e kind;
    logic [7:0]  data;
    logic        last;
  } entry_t;

  csvfs_ctx_t      ctx;
  logic            in_acc, out_acc;
  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr_nxt;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic [PtrW:0]   push;

  // Accept only while two free slots remain for a worst-case beat.
  assign s_axis_tready = (cnt_q <= (PtrW+1)'(Depth - 2));
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_acc       = m_axis_tvalid & m_axis_tready;

  csvfs_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .byte_i   (s_axis_tdata),
    .eoi_i    (s_axis_tlast),
    .ctx_o    (ctx)
  );

  always_comb begin
    push   = in_acc ? (PtrW+1)'(ctx.cnt) : '0;
    wr_nxt = wr_q + PtrW'(1);
    wr_d   = wr_q + push[PtrW-1:0];
    rd_d   = out_acc ? rd_q + PtrW'(1) : rd_q;
    cnt_d  = cnt_q + push - (out_acc ? (PtrW+1)'(1) : '0);
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && ctx.cnt != 2'd0) begin
      mem_q[wr_q] <= '{kind: ctx.r0.kind, data: ctx.r0.data, last: (ctx.cnt == 2'd1)};
    end
    if (in_acc && ctx.cnt == 2'd2) begin
      mem_q[wr_nxt] <= '{kind: ctx.r1.kind, data: ctx.r1.data, last: 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = mem_q[rd_q].data;
  assign m_axis_tuser  = mem_q[rd_q].kind;
  assign m_axis_tlast  = mem_q[rd_q].last;

endmodule
